// File: hw/rtl/pdfm_pkg.sv
// Package for the PWM duty/frequency meter: item types, register map,
// controller states and the shared restoring-divider step.
// No dependencies.
package pdfm_pkg;

   localparam int FREQ_W     = 27;
   localparam int CNT_W      = 16;
   localparam int DUTY_W     = 7;
   localparam int RELOAD_W   = 17;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam int DIV_STEPS = FREQ_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [DUTY_W-1:0]   DUTY_FULL     = DUTY_W'(100);
   localparam logic [RELOAD_W-1:0] RELOAD_MARGIN = RELOAD_W'(1000);

   localparam logic [FREQ_W-1:0] TIMER_CLOCK_RESET = FREQ_W'(1000000);
   localparam logic [FREQ_W-1:0] FREQ_LOW_RESET    = FREQ_W'(1);
   localparam logic [FREQ_W-1:0] FREQ_HIGH_RESET   = FREQ_W'(100000);

   localparam logic [1:0] REG_TIMER_CLOCK = 2'd0;
   localparam logic [1:0] REG_FREQ_LOW    = 2'd1;
   localparam logic [1:0] REG_FREQ_HIGH   = 2'd2;

   localparam logic KIND_CAPTURE  = 1'b0;
   localparam logic KIND_OVERFLOW = 1'b1;

   typedef struct packed {
      logic             kind;
      logic             channel;
      logic [CNT_W-1:0] period_count;
      logic [CNT_W-1:0] high_count;
      logic             pin_level;
   } pdfm_req_type;

   typedef struct packed {
      logic                channel_out;
      logic [DUTY_W-1:0]   duty_percent;
      logic [FREQ_W-1:0]   frequency_hz;
      logic                reload_update;
      logic [RELOAD_W-1:0] reload_value;
   } pdfm_rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] timer_clock_hz;
      logic [FREQ_W-1:0] freq_low_hz;
      logic [FREQ_W-1:0] freq_high_hz;
   } pdfm_cfg_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic step;
      logic commit;
   } pdfm_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EVAL
   } pdfm_state_type;

   typedef struct packed {
      logic [CNT_W-1:0]  rem;
      logic [FREQ_W-1:0] quo;
   } pdfm_div_type;

   // One restoring step: dividend bits shift out of quo, quotient bits shift in.
   function automatic pdfm_div_type div_step(input pdfm_div_type cur,
                                             input logic [CNT_W-1:0] divisor);
      logic [CNT_W:0] trial;
      pdfm_div_type   nxt;
      trial = {cur.rem, cur.quo[FREQ_W-1]};
      if (trial >= {1'b0, divisor}) begin
         nxt.rem = CNT_W'(trial - {1'b0, divisor});
         nxt.quo = {cur.quo[FREQ_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[CNT_W-1:0];
         nxt.quo = {cur.quo[FREQ_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// File: hw/rtl/pwm_input_duty_freq_meter_core.sv
// Top level of the PWM input duty and frequency meter.
// Depends on pdfm_pkg, pdfm_regs, pdfm_ctrl, pdfm_dpath.
//
//   channel   ports                               direction  payload
//   request   req_valid / req_stall / req_item    in         pdfm_req_type
//   response  rsp_valid / rsp_stall / rsp_item    out        pdfm_rsp_type
//   config    psel penable pwrite paddr pwdata    in/out     three 27-bit registers
//
// After the accepting edge an item goes through operand load, 27 steps of the
// two restoring dividers (frequency and duty run side by side), and the
// evaluation state that forms the result. An item is taken only while the block
// is idle, so no new item is taken before the last one is committed. The next is
// accepted while the previous result still waits in the output register.
// Synchronous active-high reset; a stalled result holds until taken.
module pwm_input_duty_freq_meter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  pdfm_pkg::pdfm_req_type          req_item,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output pdfm_pkg::pdfm_rsp_type          rsp_item,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [pdfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import pdfm_pkg::*;

   pdfm_cfg_type cfg;
   pdfm_cmd_type cmd;

   pdfm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pdfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   pdfm_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_item (req_item),
      .rsp_item (rsp_item)
   );

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while another is in work");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.duty_percent <= DUTY_FULL)
      else $error("duty above full scale");

   a_reload_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_item.reload_update
      |=> !(rsp_valid && rsp_item.reload_update))
      else $error("reload issued twice");

   a_reload_margin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.reload_update |-> rsp_item.reload_value >= RELOAD_MARGIN)
      else $error("reload value below margin");

endmodule

// File: hw/rtl/pdfm_regs.sv
// Configuration registers of the PWM meter behind an APB-style port.
// Depends on pdfm_pkg.
module pdfm_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [pdfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [pdfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [pdfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output pdfm_pkg::pdfm_cfg_type         cfg
);
   import pdfm_pkg::*;

   pdfm_cfg_type cfg_ff, cfg_in;
   logic [1:0]   index;
   logic         wr_en;

   assign index  = paddr[CSR_ADDR_W-1:2];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_TIMER_CLOCK: cfg_in.timer_clock_hz = pwdata[FREQ_W-1:0];
            REG_FREQ_LOW:    cfg_in.freq_low_hz    = pwdata[FREQ_W-1:0];
            REG_FREQ_HIGH:   cfg_in.freq_high_hz   = pwdata[FREQ_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_TIMER_CLOCK: prdata = CSR_DATA_W'(cfg_ff.timer_clock_hz);
         REG_FREQ_LOW:    prdata = CSR_DATA_W'(cfg_ff.freq_low_hz);
         REG_FREQ_HIGH:   prdata = CSR_DATA_W'(cfg_ff.freq_high_hz);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timer_clock_hz <= TIMER_CLOCK_RESET;
         cfg_ff.freq_low_hz    <= FREQ_LOW_RESET;
         cfg_ff.freq_high_hz   <= FREQ_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/pdfm_ctrl.sv
// Sequencer of the PWM meter: item handshake, divider step count,
// result valid. Depends on pdfm_pkg.
module pdfm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pdfm_pkg::pdfm_cmd_type cmd
);
   import pdfm_pkg::*;

   pdfm_state_type         state_ff, state_in;
   logic [DIV_CNT_W-1:0]   count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_free;

   assign out_free  = ~(rsp_valid_ff & rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            count_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            count_in = count_ff + DIV_CNT_W'(1);
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.commit | ~out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/pdfm_dpath.sv
// Datapath of the PWM meter: item register, two restoring dividers,
// learning state and result register. Depends on pdfm_pkg.
module pdfm_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  pdfm_pkg::pdfm_cmd_type cmd,
   input  pdfm_pkg::pdfm_cfg_type cfg,
   input  pdfm_pkg::pdfm_req_type req_item,
   output pdfm_pkg::pdfm_rsp_type rsp_item
);
   import pdfm_pkg::*;

   pdfm_req_type      item_ff, item_in;
   pdfm_div_type      freq_div_ff, freq_div_in;
   pdfm_div_type      duty_div_ff, duty_div_in;
   pdfm_rsp_type      rsp_ff, rsp_in;
   logic              learned_ff, learned_in;
   logic [FREQ_W-1:0] last_freq_ff, last_freq_in;

   logic [CNT_W:0]    high_adj;
   logic [23:0]       duty_num;
   logic              in_band;
   logic              period_zero;

   assign rsp_item    = rsp_ff;
   assign period_zero = (item_ff.period_count == '0);
   assign high_adj    = {1'b0, item_ff.high_count} + (CNT_W+1)'(item_ff.channel);
   assign duty_num    = 24'(high_adj) * 24'(DUTY_FULL);
   assign in_band     = (freq_div_ff.quo >= cfg.freq_low_hz) &&
                        (freq_div_ff.quo <= cfg.freq_high_hz);

   always_comb begin
      item_in      = item_ff;
      freq_div_in  = freq_div_ff;
      duty_div_in  = duty_div_ff;
      rsp_in       = rsp_ff;
      learned_in   = learned_ff;
      last_freq_in = last_freq_ff;

      if (cmd.capture) begin
         item_in = req_item;
      end
      if (cmd.load) begin
         freq_div_in.rem = '0;
         freq_div_in.quo = cfg.timer_clock_hz;
         duty_div_in.rem = '0;
         duty_div_in.quo = FREQ_W'(duty_num);
      end
      if (cmd.step) begin
         freq_div_in = div_step(freq_div_ff, item_ff.period_count);
         duty_div_in = div_step(duty_div_ff, item_ff.period_count);
      end
      if (cmd.commit) begin
         rsp_in               = '0;
         rsp_in.channel_out   = item_ff.channel;
         if (item_ff.kind == KIND_OVERFLOW) begin
            rsp_in.duty_percent = item_ff.pin_level ? DUTY_FULL : '0;
         end else if (!period_zero) begin
            rsp_in.duty_percent = (duty_div_ff.quo > FREQ_W'(DUTY_FULL)) ?
                                  DUTY_FULL : duty_div_ff.quo[DUTY_W-1:0];
            rsp_in.frequency_hz = freq_div_ff.quo;
            if (in_band) begin
               if (!learned_ff && (last_freq_ff == freq_div_ff.quo)) begin
                  rsp_in.reload_update = 1'b1;
                  rsp_in.reload_value  = RELOAD_W'(item_ff.period_count) + RELOAD_MARGIN;
                  learned_in           = 1'b1;
               end
               last_freq_in = freq_div_ff.quo;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      freq_div_ff <= freq_div_in;
      duty_div_ff <= duty_div_in;
      rsp_ff      <= rsp_in;
      if (reset) begin
         learned_ff   <= 1'b0;
         last_freq_ff <= '0;
      end else begin
         learned_ff   <= learned_in;
         last_freq_ff <= last_freq_in;
      end
   end

endmodule

// File: tb/tb.sv
// Self-checking testbench for pwm_input_duty_freq_meter_core: drives capture and
// overflow items under changing register settings and checks every result against
// an in-bench model of the duty, frequency and reload learning. Needs pdfm_pkg.
`timescale 1ns / 1ps

module tb;
   import pdfm_pkg::*;

   localparam logic [1:0] REG_UNMAPPED = 2'd3;
   localparam int unsigned IDLE_LIMIT = 3000;
   localparam int unsigned DRAIN_CYCLES = 40;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   pdfm_req_type          req_item = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   pdfm_rsp_type          rsp_item;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   pwm_input_duty_freq_meter_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // meter model state
   logic [FREQ_W-1:0] cfg_clock = TIMER_CLOCK_RESET;
   logic [FREQ_W-1:0] cfg_low   = FREQ_LOW_RESET;
   logic [FREQ_W-1:0] cfg_high  = FREQ_HIGH_RESET;
   logic              reload_learned = 1'b0;
   logic [FREQ_W-1:0] last_in_band = '0;

   pdfm_rsp_type pending_meas[$];
   bit           burst_mode = 1'b0;
   int unsigned  errors = 0;
   int unsigned  items_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  reloads_seen = 0;
   int unsigned  settings_applied = 0;
   int unsigned  idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic pdfm_rsp_type meter_predict(input pdfm_req_type it);
      pdfm_rsp_type      r;
      logic [CNT_W:0]    hi;
      logic [31:0]       duty;
      logic [FREQ_W-1:0] f;
      r = '0;
      r.channel_out = it.channel;
      if (it.kind == KIND_OVERFLOW) begin
         r.duty_percent = it.pin_level ? DUTY_FULL : '0;
      end else if (it.period_count != '0) begin
         hi = {1'b0, it.high_count} + (CNT_W+1)'(it.channel);
         duty = (32'(hi) * 32'(DUTY_FULL)) / 32'(it.period_count);
         if (duty > 32'(DUTY_FULL)) begin
            duty = 32'(DUTY_FULL);
         end
         r.duty_percent = DUTY_W'(duty);
         f = cfg_clock / FREQ_W'(it.period_count);
         r.frequency_hz = f;
         if (f >= cfg_low && f <= cfg_high) begin
            if (!reload_learned && last_in_band == f) begin
               r.reload_update = 1'b1;
               r.reload_value = RELOAD_W'(it.period_count) + RELOAD_MARGIN;
               reload_learned = 1'b1;
            end
            last_in_band = f;
         end
      end
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   function automatic pdfm_req_type mk_item(input logic kind, input logic chan,
                                            input logic [CNT_W-1:0] period,
                                            input logic [CNT_W-1:0] high,
                                            input logic pin);
      pdfm_req_type it;
      it.kind = kind;
      it.channel = chan;
      it.period_count = period;
      it.high_count = high;
      it.pin_level = pin;
      return it;
   endfunction

   function automatic pdfm_req_type random_item();
      pdfm_req_type it;
      it.kind = ($urandom_range(0, 5) == 0) ? KIND_OVERFLOW : KIND_CAPTURE;
      it.channel = 1'($urandom_range(0, 1));
      it.pin_level = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: it.period_count = '0;
         1, 2: it.period_count = CNT_W'($urandom_range(1, 16));
         3, 4: it.period_count = CNT_W'($urandom_range(17, 2000));
         5: it.period_count = '1;
         default: it.period_count = CNT_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: it.high_count = '0;
         1: it.high_count = '1;
         2: it.high_count = it.period_count - CNT_W'(1);
         3: it.high_count = it.period_count;
         4: it.high_count = it.period_count + CNT_W'(1);
         5: it.high_count = CNT_W'($urandom);
         default: it.high_count = CNT_W'($urandom_range(0, it.period_count));
      endcase
      return it;
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      errors++;
      if (errors <= 30) begin
         $display("tb: mismatch %s: got %0d want %0d (result %0d)", what, got, want,
                  results_checked);
      end
   endtask

   task automatic send_item(input pdfm_req_type it);
      int unsigned gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      pending_meas.push_back(meter_predict(it));
      items_sent++;
   endtask

   // stop sending and let the block go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_meas.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_TIMER_CLOCK: cfg_clock = data[FREQ_W-1:0];
         REG_FREQ_LOW:    cfg_low = data[FREQ_W-1:0];
         REG_FREQ_HIGH:   cfg_high = data[FREQ_W-1:0];
         default: ;
      endcase
   endtask

   task automatic csr_read_check(input logic [1:0] idx);
      logic [CSR_DATA_W-1:0] want;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_TIMER_CLOCK: want = CSR_DATA_W'(cfg_clock);
         REG_FREQ_LOW:    want = CSR_DATA_W'(cfg_low);
         default:         want = CSR_DATA_W'(cfg_high);
      endcase
      if (prdata !== want) report_mismatch("register readback", prdata, want);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_config(input logic [CSR_DATA_W-1:0] clk_word,
                               input logic [CSR_DATA_W-1:0] low_word,
                               input logic [CSR_DATA_W-1:0] high_word);
      settle();
      csr_write(REG_TIMER_CLOCK, clk_word);
      csr_write(REG_FREQ_LOW, low_word);
      csr_write(REG_FREQ_HIGH, high_word);
      settings_applied++;
   endtask

   // reset settings; learns a reload once two in-band frequencies repeat
   task automatic test_directed();
      send_item(mk_item(KIND_OVERFLOW, 1'b0, '1, '1, 1'b1));
      send_item(mk_item(KIND_OVERFLOW, 1'b1, '0, '0, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b1, '0, '1, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b0, '0, '0, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd60000, 16'd30000, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd1, '1, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b1, 16'd1, '0, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b1, '1, '1, 1'b0));
      send_item(mk_item(KIND_OVERFLOW, 1'b0, '1, '0, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b0, '1, 16'hFFFE, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b1, '1, '0, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd10, 16'd5, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b1, 16'd10, 16'd9, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd9, 16'd10, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd10, 16'd5, 1'b0));
   endtask

   task automatic test_register_access();
      apply_config(32'd5000000, 32'd20, 32'd4000000);
      csr_read_check(REG_TIMER_CLOCK);
      csr_read_check(REG_FREQ_LOW);
      csr_read_check(REG_FREQ_HIGH);
      csr_write(REG_UNMAPPED, 32'hFFFF_FFFF);
      csr_write(REG_FREQ_HIGH, 32'hF800_0000 | 32'd3000000);
      csr_read_check(REG_TIMER_CLOCK);
      csr_read_check(REG_FREQ_LOW);
      csr_read_check(REG_FREQ_HIGH);
      repeat (12) send_item(random_item());
   endtask

   task automatic run_edge_items(input int unsigned n_random);
      send_item(mk_item(KIND_CAPTURE, 1'b0, 16'd1, '0, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b1, 16'd1, '1, 1'b1));
      send_item(mk_item(KIND_CAPTURE, 1'b1, '1, '1, 1'b0));
      send_item(mk_item(KIND_CAPTURE, 1'b0, '0, 16'd7, 1'b1));
      send_item(mk_item(KIND_OVERFLOW, 1'b1, 16'd3, 16'd3, 1'b1));
      repeat (n_random) send_item(random_item());
   endtask

   task automatic test_config_extremes();
      apply_config(32'd100000000, 32'd0, 32'd100000000);
      run_edge_items(10);
      // zero clock with a band that admits zero frequency
      apply_config(32'd0, 32'd0, 32'd0);
      run_edge_items(10);
      apply_config(32'd1, 32'd1, 32'd1);
      run_edge_items(10);
      // inverted band
      apply_config(32'd1000000, 32'd100000000, 32'd0);
      run_edge_items(10);
      apply_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      csr_read_check(REG_TIMER_CLOCK);
      run_edge_items(10);
   endtask

   task automatic test_random();
      logic [CSR_DATA_W-1:0] clk_word;
      logic [CSR_DATA_W-1:0] fa;
      logic [CSR_DATA_W-1:0] fb;
      for (int phase = 0; phase < 7; phase++) begin
         case ($urandom_range(0, 3))
            0: clk_word = 32'd100000000;
            1: clk_word = $urandom_range(1, 100000000);
            2: clk_word = $urandom_range(1000, 2000000);
            default: clk_word = $urandom_range(1, 70000);
         endcase
         fa = clk_word / $urandom_range(1, 65535);
         fb = clk_word / $urandom_range(1, 200);
         if ($urandom_range(0, 5) == 0) begin
            apply_config(clk_word, fb, fa);
         end else begin
            apply_config(clk_word, fa, fb);
         end
         if ($urandom_range(0, 2) == 0) begin
            csr_write(REG_TIMER_CLOCK, clk_word | ($urandom << FREQ_W));
         end
         burst_mode = ($urandom_range(0, 3) == 0);
         repeat (66) send_item(random_item());
         burst_mode = 1'b0;
      end
   endtask

   // result side back-pressure: ready runs, occasionally long, between stalls
   initial begin : rsp_stall_gen
      int unsigned run_len;
      int unsigned stall_len;
      wait (!reset);
      forever begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 8);
         stall_len = pick_gap();
         @(posedge clock);
         rsp_stall <= 1'b0;
         repeat (run_len - 1) @(posedge clock);
         if (stall_len != 0) begin
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (stall_len - 1) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      pdfm_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_meas.size() == 0) begin
            report_mismatch("result with none pending", rsp_item.frequency_hz, 0);
         end else begin
            want = pending_meas.pop_front();
            if (rsp_item.channel_out !== want.channel_out)
               report_mismatch("channel_out", rsp_item.channel_out, want.channel_out);
            if (rsp_item.duty_percent !== want.duty_percent)
               report_mismatch("duty_percent", rsp_item.duty_percent, want.duty_percent);
            if (rsp_item.frequency_hz !== want.frequency_hz)
               report_mismatch("frequency_hz", rsp_item.frequency_hz, want.frequency_hz);
            if (rsp_item.reload_update !== want.reload_update)
               report_mismatch("reload_update", rsp_item.reload_update, want.reload_update);
            if (rsp_item.reload_value !== want.reload_value)
               report_mismatch("reload_value", rsp_item.reload_value, want.reload_value);
            if (want.reload_update) reloads_seen++;
         end
         results_checked++;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: no progress for %0d cycles", IDLE_LIMIT);
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_access();
      test_config_extremes();
      test_random();
      settle();
      $display("tb: %0d items sent, %0d results checked, %0d reload(s) learned",
               items_sent, results_checked, reloads_seen);
      $display("tb: %0d register settings incl. zero clock, inverted and masked values",
               settings_applied);
      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
